// File: rtl/tfsb_pkg.sv
// ----------------------------------------------------------------------------
// tfsb_pkg: shared types, constants and functions of the scaled blit
// Field widths, register codes, reset values, pixel packing and tiled index.
// ----------------------------------------------------------------------------
package tfsb_pkg;

  localparam int unsigned COLOR_W         = 8;
  localparam int unsigned DIM_W           = 11;
  localparam int unsigned SCALE_W         = 4;
  localparam int unsigned PITCH_W         = 7;
  localparam int unsigned POS_W           = 16;
  localparam int unsigned IDX_W           = 21;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned REG_IDX_W       = 3;
  localparam int unsigned TILE_SHIFT      = 5;
  localparam int unsigned TILE_MASK       = 31;
  localparam int unsigned DEF_MAX_SCALE   = 3;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam logic [DIM_W-1:0] RST_FB_WIDTH   = 11'd1280;
  localparam logic [DIM_W-1:0] RST_FB_HEIGHT  = 11'd720;
  localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 11'd256;
  localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 11'd240;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FB_WIDTH     = 3'd0,
    REG_FB_HEIGHT    = 3'd1,
    REG_SRC_WIDTH    = 3'd2,
    REG_SRC_HEIGHT   = 3'd3,
    REG_TEN_BIT_MODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] fb_width;
    logic [DIM_W-1:0] fb_height;
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    logic             ten_bit_mode;
  } cfg_regs_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DIM_W-1:0]   off_x;
    logic [DIM_W-1:0]   off_y;
    logic [PITCH_W-1:0] pitch32;
  } derived_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [DIM_W-1:0]   x0;
    logic [DIM_W-1:0]   y0;
    logic [SCALE_W-1:0] nx;
    logic [SCALE_W-1:0] ny;
    logic [PITCH_W-1:0] pitch32;
  } entry_t;

  function automatic logic [WORD_W-1:0] pack_word(input logic [COLOR_W-1:0] r,
                                                  input logic [COLOR_W-1:0] g,
                                                  input logic [COLOR_W-1:0] b,
                                                  input logic ten);
    logic [WORD_W-1:0] n;
    n = {2'b11, r, r[7:6], g, g[7:6], b, b[7:6]};
    if (ten) begin
      return {n[7:0], n[15:8], n[23:16], n[31:24]};
    end
    return {b, g, r, 8'hff};
  endfunction

  function automatic logic [IDX_W-1:0] tile_index(input logic [DIM_W-1:0] x,
                                                  input logic [DIM_W-1:0] y,
                                                  input logic [PITCH_W-1:0] pitch32);
    logic [DIM_W-TILE_SHIFT+PITCH_W-1:0] rows;
    logic [DIM_W-1:0]                    hi;
    rows = (DIM_W-TILE_SHIFT+PITCH_W)'(y[DIM_W-1:TILE_SHIFT]) *
           (DIM_W-TILE_SHIFT+PITCH_W)'(pitch32);
    hi = rows[DIM_W-1:0] + DIM_W'(x[DIM_W-1:TILE_SHIFT]);
    return {hi, y[4:1], x[4] ^ y[3], x[3:2], y[0], x[1:0]};
  endfunction

endpackage

// File: rtl/tfsb_pix_if.sv
// ----------------------------------------------------------------------------
// tfsb_pix_if: source pixel channel
// Valid/ready channel carrying one RGB888 source pixel per transfer.
// ----------------------------------------------------------------------------
interface tfsb_pix_if;
  logic                         valid;
  logic                         ready;
  logic [tfsb_pkg::COLOR_W-1:0] red;
  logic [tfsb_pkg::COLOR_W-1:0] green;
  logic [tfsb_pkg::COLOR_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// File: rtl/tfsb_wr_if.sv
// ----------------------------------------------------------------------------
// tfsb_wr_if: framebuffer write channel
// Valid/ready channel carrying one tiled word index and pixel word per transfer.
// ----------------------------------------------------------------------------
interface tfsb_wr_if;
  logic                        valid;
  logic                        ready;
  logic [tfsb_pkg::IDX_W-1:0]  write_index;
  logic [tfsb_pkg::WORD_W-1:0] write_word;
  logic                        run_end;

  modport source (output valid, write_index, write_word, run_end, input ready);
  modport sink (input valid, write_index, write_word, run_end, output ready);
endinterface

// File: rtl/tfsb_cfg_if.sv
// ----------------------------------------------------------------------------
// tfsb_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per transfer.
// ----------------------------------------------------------------------------
interface tfsb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tfsb_pkg::REG_IDX_W-1:0] index;
  logic [tfsb_pkg::DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/tiled_framebuffer_scaled_blit.sv
// ----------------------------------------------------------------------------
// tiled_framebuffer_scaled_blit: scaled blit into a 32x32-tiled framebuffer
// Packs each source pixel into a 32-bit word and writes it scale x scale
// times at centered, clipped, tiled word indices.
// ----------------------------------------------------------------------------
//   Channel  Role    Per transfer
//   cfg      sink    register index and 11-bit data
//   pix      sink    one RGB888 source pixel
//   wr       source  one tiled word index, pixel word and run_end flag
//
// The intake takes one pixel per cycle unless held; the write generator issues
// one write per cycle unless stalled, so a pixel costs scale x scale writes
// (one to nine at the default scale limit), fewer if the run is clipped. The
// first write passes the intake stages, the run queue and the output register.
// A synchronous reset restores the default registers and needs no clearing
// pass. No pixel is taken in a cycle that carries a configuration transfer, and
// a stalled write output only holds the intake once the run queue is full.
module tiled_framebuffer_scaled_blit #(
  parameter int unsigned MAX_SCALE   = tfsb_pkg::DEF_MAX_SCALE,
  parameter int unsigned QUEUE_DEPTH = tfsb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  tfsb_cfg_if.sink  cfg,
  tfsb_pix_if.sink  pix,
  tfsb_wr_if.source wr
);
  import tfsb_pkg::*;

  cfg_regs_t regs;
  derived_t  fresh;
  logic      push_valid;
  entry_t    push_data;
  logic      push_ready;
  logic      pop_valid;
  entry_t    pop_data;
  logic      pop_ready;

  assign cfg.ready = 1'b1;

  tfsb_regs #(
    .MAX_SCALE (MAX_SCALE)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .regs     (regs),
    .fresh    (fresh)
  );

  tfsb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .cfg_busy   (cfg.valid),
    .regs       (regs),
    .fresh      (fresh),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  tfsb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  tfsb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .wr        (wr)
  );

endmodule

// File: rtl/tfsb_regs.sv
// ----------------------------------------------------------------------------
// tfsb_regs: configuration registers and geometry derivation
// Holds the registers and derives scale, centering offsets and tile pitch
// from them over two register stages.
// ----------------------------------------------------------------------------
module tfsb_regs #(
  parameter int unsigned MAX_SCALE = tfsb_pkg::DEF_MAX_SCALE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [tfsb_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [tfsb_pkg::DIM_W-1:0]     wr_data,
  output tfsb_pkg::cfg_regs_t            regs,
  output tfsb_pkg::derived_t             fresh
);
  import tfsb_pkg::*;

  localparam int unsigned PROD_W = DIM_W + SCALE_W;
  localparam int unsigned SUM_W  = DIM_W + 1;

  logic [MAX_SCALE-1:0] fits;
  logic [SCALE_W-1:0]   fit_count;
  logic [SCALE_W-1:0]   scale_next;
  logic [SCALE_W-1:0]   scale;
  logic [PROD_W-1:0]    span_w;
  logic [PROD_W-1:0]    span_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fb_width     <= RST_FB_WIDTH;
      regs.fb_height    <= RST_FB_HEIGHT;
      regs.src_width    <= RST_SRC_WIDTH;
      regs.src_height   <= RST_SRC_HEIGHT;
      regs.ten_bit_mode <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_FB_WIDTH:     regs.fb_width     <= wr_data;
        REG_FB_HEIGHT:    regs.fb_height    <= wr_data;
        REG_SRC_WIDTH:    regs.src_width    <= wr_data;
        REG_SRC_HEIGHT:   regs.src_height   <= wr_data;
        REG_TEN_BIT_MODE: regs.ten_bit_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  // The scale is the largest factor up to MAX_SCALE at which the source fits both ways, else one.
  always_comb begin
    for (int k = 0; k < MAX_SCALE; k++) begin
      fits[k] = (PROD_W'(regs.src_width) * PROD_W'(k + 1) <= PROD_W'(regs.fb_width)) &&
                (PROD_W'(regs.src_height) * PROD_W'(k + 1) <= PROD_W'(regs.fb_height));
    end
    fit_count = SCALE_W'($countones(fits));
    if (regs.src_width == '0 || regs.src_height == '0 || fit_count == '0) begin
      scale_next = SCALE_W'(1);
    end else begin
      scale_next = fit_count;
    end
  end

  always_comb begin
    span_w = PROD_W'(regs.src_width) * PROD_W'(scale);
    span_h = PROD_W'(regs.src_height) * PROD_W'(scale);
  end

  always_ff @(posedge clk) begin
    scale         <= scale_next;
    fresh.scale   <= scale;
    fresh.off_x   <= (span_w >= PROD_W'(regs.fb_width)) ? '0 :
                     DIM_W'((PROD_W'(regs.fb_width) - span_w) >> 1);
    fresh.off_y   <= (span_h >= PROD_W'(regs.fb_height)) ? '0 :
                     DIM_W'((PROD_W'(regs.fb_height) - span_h) >> 1);
    fresh.pitch32 <= PITCH_W'((SUM_W'(regs.fb_width) + SUM_W'(TILE_MASK)) >> TILE_SHIFT);
  end

endmodule

// File: rtl/tfsb_front.sv
// ----------------------------------------------------------------------------
// tfsb_front: pixel intake and classification
// Tracks the source position, packs the pixel word, places the enlarged pixel
// in the framebuffer and clips it, then hands any run with writes to the queue.
// ----------------------------------------------------------------------------
module tfsb_front (
  input  logic                clk,
  input  logic                rst,
  tfsb_pix_if.sink            pix,
  input  logic                cfg_busy,
  input  tfsb_pkg::cfg_regs_t regs,
  input  tfsb_pkg::derived_t  fresh,
  output logic                push_valid,
  output tfsb_pkg::entry_t    push_data,
  input  logic                push_ready
);
  import tfsb_pkg::*;

  logic [DIM_W-1:0]   col;
  logic [DIM_W-1:0]   row;
  logic [DIM_W-1:0]   col_next;
  logic [DIM_W-1:0]   row_next;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic               size_ok;
  logic               accept;

  logic               valid0;
  logic [COLOR_W-1:0] red0;
  logic [COLOR_W-1:0] green0;
  logic [COLOR_W-1:0] blue0;
  logic [DIM_W-1:0]   col0;
  logic [DIM_W-1:0]   row0;
  logic               first0;

  logic               valid1;
  logic [WORD_W-1:0]  word1;
  logic [DIM_W-1:0]   col1;
  logic [DIM_W-1:0]   row1;
  logic               first1;

  logic               valid2;
  logic [WORD_W-1:0]  word2;
  logic [POS_W-1:0]   dx2;
  logic [POS_W-1:0]   dy2;
  logic [SCALE_W-1:0] scale2;
  logic [PITCH_W-1:0] pitch2;

  derived_t           snap;
  derived_t           geo;
  logic [POS_W-1:0]   rem_x;
  logic [POS_W-1:0]   rem_y;
  logic [SCALE_W-1:0] nx;
  logic [SCALE_W-1:0] ny;
  logic               has_writes;
  logic               free0;
  logic               free1;
  logic               free2;

  assign size_ok   = (regs.src_width != '0) && (regs.src_height != '0);
  assign free2     = !valid2 || push_ready || !has_writes;
  assign free1     = !valid1 || free2;
  assign free0     = !valid0 || free1;
  assign pix.ready = free0 && !cfg_busy && !rst;
  assign accept    = pix.valid && pix.ready;

  always_comb begin
    col_inc  = col + DIM_W'(1);
    row_inc  = row + DIM_W'(1);
    col_next = col_inc;
    row_next = row;
    if (col_inc >= regs.src_width) begin
      col_next = '0;
      row_next = (row_inc >= regs.src_height) ? '0 : row_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept && size_ok) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      if (free0) begin
        valid0 <= accept && size_ok;
      end
      if (free1) begin
        valid1 <= valid0;
      end
      if (free2) begin
        valid2 <= valid1;
      end
    end
  end

  // A pixel at the frame origin takes freshly derived geometry; the rest of
  // the frame keeps the geometry captured then.
  assign geo = first1 ? fresh : snap;

  always_ff @(posedge clk) begin
    if (free0) begin
      red0   <= pix.red;
      green0 <= pix.green;
      blue0  <= pix.blue;
      col0   <= col;
      row0   <= row;
      first0 <= (col == '0) && (row == '0);
    end
    if (free1) begin
      word1  <= pack_word(red0, green0, blue0, regs.ten_bit_mode);
      col1   <= col0;
      row1   <= row0;
      first1 <= first0;
    end
    if (free2) begin
      word2  <= word1;
      dx2    <= POS_W'(geo.off_x) + POS_W'(col1) * POS_W'(geo.scale);
      dy2    <= POS_W'(geo.off_y) + POS_W'(row1) * POS_W'(geo.scale);
      scale2 <= geo.scale;
      pitch2 <= geo.pitch32;
    end
    if (free2 && valid1 && first1) begin
      snap <= fresh;
    end
  end

  always_comb begin
    rem_x = POS_W'(regs.fb_width) - dx2;
    rem_y = POS_W'(regs.fb_height) - dy2;
    if (dx2 >= POS_W'(regs.fb_width)) begin
      nx = '0;
    end else if (rem_x < POS_W'(scale2)) begin
      nx = SCALE_W'(rem_x);
    end else begin
      nx = scale2;
    end
    if (dy2 >= POS_W'(regs.fb_height)) begin
      ny = '0;
    end else if (rem_y < POS_W'(scale2)) begin
      ny = SCALE_W'(rem_y);
    end else begin
      ny = scale2;
    end
    has_writes = (nx != '0) && (ny != '0);
  end

  assign push_valid        = valid2 && has_writes;
  assign push_data.word    = word2;
  assign push_data.x0      = dx2[DIM_W-1:0];
  assign push_data.y0      = dy2[DIM_W-1:0];
  assign push_data.nx      = nx;
  assign push_data.ny      = ny;
  assign push_data.pitch32 = pitch2;

endmodule

// File: rtl/tfsb_queue.sv
// ----------------------------------------------------------------------------
// tfsb_queue: run descriptor queue
// Short first-in first-out buffer between the intake and the write generator.
// ----------------------------------------------------------------------------
module tfsb_queue #(
  parameter int unsigned DEPTH = tfsb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  tfsb_pkg::entry_t push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output tfsb_pkg::entry_t pop_data,
  input  logic             pop_ready
);
  import tfsb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/tfsb_back.sv
// ----------------------------------------------------------------------------
// tfsb_back: framebuffer write generator
// Walks the clipped block of each run row by row and issues one tiled write
// per cycle unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module tfsb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  input  tfsb_pkg::entry_t pop_data,
  output logic             pop_ready,
  tfsb_wr_if.source        wr
);
  import tfsb_pkg::*;

  logic [SCALE_W-1:0] xx;
  logic [SCALE_W-1:0] yy;
  logic               out_valid;
  logic [IDX_W-1:0]   out_index;
  logic [WORD_W-1:0]  out_word;
  logic               out_run_end;
  logic               load;
  logic               advance;
  logic               last_x;
  logic               last;

  assign load      = !out_valid || wr.ready;
  assign advance   = pop_valid && load;
  assign last_x    = (xx == pop_data.nx - SCALE_W'(1));
  assign last      = last_x && (yy == pop_data.ny - SCALE_W'(1));
  assign pop_ready = advance && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      xx        <= '0;
      yy        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= pop_valid;
      end
      if (advance) begin
        if (last_x) begin
          xx <= '0;
          yy <= last ? '0 : yy + SCALE_W'(1);
        end else begin
          xx <= xx + SCALE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_index   <= tile_index(pop_data.x0 + DIM_W'(xx), pop_data.y0 + DIM_W'(yy),
                                pop_data.pitch32);
      out_word    <= pop_data.word;
      out_run_end <= last;
    end
  end

  assign wr.valid       = out_valid;
  assign wr.write_index = out_index;
  assign wr.write_word  = out_word;
  assign wr.run_end     = out_run_end;

endmodule

// File: rtl/tfsb_checker.sv
// ----------------------------------------------------------------------------
// tfsb_checker: port-level checks of the scaled blit
// Watches the top-level channels over time and is attached by a bind.
// ----------------------------------------------------------------------------
module tfsb_checker (
  input logic       clk,
  input logic       rst,
  tfsb_cfg_if.sink  cfg,
  tfsb_pix_if.sink  pix,
  tfsb_wr_if.source wr
);

  a_wr_hold: assert property (@(posedge clk) disable iff (rst)
    wr.valid && !wr.ready |=> wr.valid && $stable(wr.write_index) &&
                             $stable(wr.write_word) && $stable(wr.run_end))
    else $error("Stalled write changed before its transfer.");

  a_rst_clears_wr: assert property (@(posedge clk) rst |=> !wr.valid)
    else $error("Write output valid right after reset.");

  a_cfg_blocks_pix: assert property (@(posedge clk) cfg.valid || rst |-> !pix.ready)
    else $error("Pixel intake open during a configuration transfer or reset.");

  a_word_alpha: assert property (@(posedge clk) disable iff (rst)
    wr.valid |-> wr.write_word[7:6] == 2'b11)
    else $error("Pixel word lost its alpha bits.");

endmodule

bind tiled_framebuffer_scaled_blit tfsb_checker u_checker (
  .clk (clk),
  .rst (rst),
  .cfg (cfg),
  .pix (pix),
  .wr  (wr)
);

// File: test/tfsb_write_checker.sv
// ----------------------------------------------------------------------------
// tfsb_write_checker: framebuffer write predictor and comparator
// Watches the configuration, pixel and write channels of the scaled blit. It
// keeps its own copy of the registers, source counters, scale and centering
// offsets, and turns every accepted pixel into the run of framebuffer writes it
// should cause. Each write transfer is compared with the oldest pending one.
// ----------------------------------------------------------------------------
module tfsb_write_checker (
  input  logic        clk,
  input  logic        rst,
  tfsb_cfg_if         cfg,
  tfsb_pix_if         pix,
  tfsb_wr_if          wr,
  output int unsigned fail_count,
  output int unsigned writes_pending,
  output int unsigned pixels_seen,
  output int unsigned writes_seen
);
  import tfsb_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] word;
    logic              run_end;
  } fb_write_t;

  fb_write_t   pending_writes[$];
  fb_write_t   wanted;
  cfg_regs_t   regs;
  int unsigned src_x;
  int unsigned src_y;
  int unsigned blit_scale;
  int unsigned center_x;
  int unsigned center_y;
  int unsigned pitch_px;

  function automatic void rederive();
    int unsigned s;
    int unsigned dw;
    int unsigned dh;
    s = 0;
    if (regs.src_width != 0 && regs.src_height != 0) begin
      s = regs.fb_width / regs.src_width;
      if (regs.fb_height / regs.src_height < s) begin
        s = regs.fb_height / regs.src_height;
      end
    end
    if (s == 0) begin
      s = 1;
    end
    if (s > DEF_MAX_SCALE) begin
      s = DEF_MAX_SCALE;
    end
    blit_scale = s;
    dw = regs.src_width * s;
    dh = regs.src_height * s;
    center_x = (dw >= regs.fb_width) ? 0 : (regs.fb_width - dw) / 2;
    center_y = (dh >= regs.fb_height) ? 0 : (regs.fb_height - dh) / 2;
    pitch_px = (regs.fb_width + 31) & ~32'd31;
  endfunction

  function automatic logic [IDX_W-1:0] tiled_word_index(input int unsigned x,
                                                       input int unsigned y);
    int unsigned v;
    v = (y >> 5) * 32 * pitch_px + ((x >> 5) << 10) + (x & 3) + ((y & 1) << 2)
        + (((x & 31) >> 2) << 3) + (((y & 31) >> 1) << 6);
    v = v ^ ((y & 8) << 2);
    return v[IDX_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] packed_pixel(input logic [7:0] r,
                                                    input logic [7:0] g,
                                                    input logic [7:0] b);
    logic [9:0]        r10;
    logic [9:0]        g10;
    logic [9:0]        b10;
    logic [WORD_W-1:0] n;
    if (!regs.ten_bit_mode) begin
      return {b, g, r, 8'hff};
    end
    r10 = {r, r[7:6]};
    g10 = {g, g[7:6]};
    b10 = {b, b[7:6]};
    n = {2'b11, r10, g10, b10};
    return {n[7:0], n[15:8], n[23:16], n[31:24]};
  endfunction

  function automatic void reset_model();
    regs = '{fb_width: RST_FB_WIDTH, fb_height: RST_FB_HEIGHT,
             src_width: RST_SRC_WIDTH, src_height: RST_SRC_HEIGHT,
             ten_bit_mode: 1'b0};
    src_x = 0;
    src_y = 0;
    rederive();
  endfunction

  function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] value);
    case (idx)
      REG_FB_WIDTH:     regs.fb_width = value;
      REG_FB_HEIGHT:    regs.fb_height = value;
      REG_SRC_WIDTH:    regs.src_width = value;
      REG_SRC_HEIGHT:   regs.src_height = value;
      REG_TEN_BIT_MODE: regs.ten_bit_mode = value[0];
      default:          return;
    endcase
    if (src_x == 0 && src_y == 0) begin
      rederive();
    end
  endfunction

  function automatic void predict_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    fb_write_t         run[$];
    int unsigned       dx;
    int unsigned       dy;
    logic [WORD_W-1:0] word;
    pixels_seen++;
    if (regs.src_width == 0 || regs.src_height == 0) begin
      return;
    end
    if (src_x == 0 && src_y == 0) begin
      rederive();
    end
    word = packed_pixel(r, g, b);
    for (int unsigned yy = 0; yy < blit_scale; yy++) begin
      dy = center_y + src_y * blit_scale + yy;
      for (int unsigned xx = 0; xx < blit_scale; xx++) begin
        dx = center_x + src_x * blit_scale + xx;
        if (dx < regs.fb_width && dy < regs.fb_height) begin
          run.push_back('{index: tiled_word_index(dx, dy), word: word, run_end: 1'b0});
        end
      end
    end
    if (run.size() != 0) begin
      run[run.size()-1].run_end = 1'b1;
    end
    foreach (run[i]) begin
      pending_writes.push_back(run[i]);
    end
    src_x = (src_x + 1) & 32'h7ff;
    if (src_x >= regs.src_width) begin
      src_x = 0;
      src_y = (src_y + 1) & 32'h7ff;
      if (src_y >= regs.src_height) begin
        src_y = 0;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("write transfer %0d: %s, expected %h, got %h", writes_seen, what, want, got);
    fail_count++;
  endtask

  task automatic check_write();
    if (pending_writes.size() == 0) begin
      report_mismatch("write with nothing pending", '0, 32'(wr.write_index));
    end else begin
      wanted = pending_writes.pop_front();
      if (wr.write_index !== wanted.index) begin
        report_mismatch("write_index", 32'(wanted.index), 32'(wr.write_index));
      end
      if (wr.write_word !== wanted.word) begin
        report_mismatch("write_word", wanted.word, wr.write_word);
      end
      if (wr.run_end !== wanted.run_end) begin
        report_mismatch("run_end", 32'(wanted.run_end), 32'(wr.run_end));
      end
    end
    writes_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      pending_writes.delete();
      fail_count = 0;
      pixels_seen = 0;
      writes_seen = 0;
    end else begin
      if (wr.valid && wr.ready) begin
        check_write();
      end
      if (cfg.valid && cfg.ready) begin
        apply_register(cfg.index, cfg.data);
      end
      if (pix.valid && pix.ready) begin
        predict_pixel(pix.red, pix.green, pix.blue);
      end
    end
    writes_pending <= pending_writes.size();
  end

endmodule

// File: test/tiled_framebuffer_scaled_blit_tb.sv
// ----------------------------------------------------------------------------
// tiled_framebuffer_scaled_blit_tb: testbench of the scaled tiled blit
// Drives register settings and source pixels into the block while the write
// side stalls on its own pattern. A short directed part covers color extremes,
// both packings, a large pitch, clipping and an empty source; random settings
// follow, most often small frames that wrap often. The checker predicts every write.
// ----------------------------------------------------------------------------
module tiled_framebuffer_scaled_blit_tb;
  import tfsb_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 470;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned DRAIN_CYCLES  = 16;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_RUNS
  } ready_pattern_t;

  typedef enum logic [2:0] {
    SMALL_FRAME,
    PARTIAL_SCALE,
    OVERSIZED_SOURCE,
    MID_FRAME_EDIT,
    EMPTY_SOURCE,
    WILD_SETTING
  } phase_kind_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_ready_q = 1'b0;

  int unsigned    fail_count;
  int unsigned    writes_pending;
  int unsigned    pixels_seen;
  int unsigned    writes_seen;
  int unsigned    cycle_count = 0;
  int unsigned    settings_run = 0;
  int unsigned    useful_pixels = 0;
  int unsigned    ignored_pixels = 0;
  int unsigned    burst_left = 0;
  int unsigned    burst_max = 1;
  int unsigned    gap_max = 0;
  int unsigned    stall_run = 0;
  ready_pattern_t ready_pattern = READY_ALWAYS;
  logic [DIM_W-1:0] cur_src_w = RST_SRC_WIDTH;
  logic [DIM_W-1:0] cur_src_h = RST_SRC_HEIGHT;

  tfsb_cfg_if cfg ();
  tfsb_pix_if pix ();
  tfsb_wr_if  wr ();

  assign wr.ready = wr_ready_q;

  tiled_framebuffer_scaled_blit i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .pix (pix),
    .wr  (wr)
  );

  tfsb_write_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .pix            (pix),
    .wr             (wr),
    .fail_count     (fail_count),
    .writes_pending (writes_pending),
    .pixels_seen    (pixels_seen),
    .writes_seen    (writes_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    case (ready_pattern)
      READY_ALWAYS: wr_ready_q <= 1'b1;
      READY_RANDOM: wr_ready_q <= ($urandom_range(0, 9) < 6);
      default: begin
        if (stall_run == 0) begin
          wr_ready_q <= ~wr_ready_q;
          stall_run <= $urandom_range(1, 8);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tiled_framebuffer_scaled_blit_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_extent(input int unsigned lo,
                                                   input int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return DIM_W'(lo);
      1:       return DIM_W'(hi);
      2:       return 11'h7ff;
      3:       return DIM_W'($urandom_range(2017, 2047));
      4:       return DIM_W'($urandom_range(0, lo));
      default: return DIM_W'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] ten_data(input logic ten);
    return {10'($urandom), ten};
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    if (idx == REG_SRC_WIDTH) begin
      cur_src_w = value;
    end
    if (idx == REG_SRC_HEIGHT) begin
      cur_src_h = value;
    end
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    if (cur_src_w != 0 && cur_src_h != 0) begin
      useful_pixels++;
    end else begin
      ignored_pixels++;
    end
  endtask

  task automatic send_random_pixels(input int unsigned count);
    repeat (count) send_pixel(pick_channel(), pick_channel(), pick_channel());
  endtask

  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    settings_run++;
  endtask

  // A one-pixel source makes the next pixel wrap both counters to zero.
  task automatic realign();
    write_reg(REG_SRC_WIDTH, 11'd1);
    write_reg(REG_SRC_HEIGHT, 11'd1);
    cfg.valid <= 1'b0;
    send_random_pixels(1);
    settle();
  endtask

  task automatic choose_pacing();
    ready_pattern = ready_pattern_t'($urandom_range(0, 2));
    burst_max = $urandom_range(1, 12);
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    burst_left = 0;
  endtask

  task automatic run_random_phase();
    phase_kind_t      kind;
    int unsigned      npx;
    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
    case ($urandom_range(0, 9))
      0, 1, 2, 8: kind = SMALL_FRAME;
      3:          kind = PARTIAL_SCALE;
      4:          kind = OVERSIZED_SOURCE;
      5, 9:       kind = MID_FRAME_EDIT;
      6:          kind = EMPTY_SOURCE;
      default:    kind = WILD_SETTING;
    endcase
    choose_pacing();
    if (kind != MID_FRAME_EDIT && $urandom_range(0, 3) != 0) begin
      realign();
    end
    fw = pick_extent(320, 1920);
    fh = pick_extent(240, 1080);
    npx = 24;
    case (kind)
      SMALL_FRAME: begin
        write_reg(REG_FB_WIDTH, fw);
        write_reg(REG_FB_HEIGHT, fh);
        write_reg(REG_SRC_WIDTH, DIM_W'($urandom_range(1, 6)));
        write_reg(REG_SRC_HEIGHT, DIM_W'($urandom_range(1, 4)));
        write_reg(REG_TEN_BIT_MODE, ten_data(1'($urandom_range(0, 1))));
        npx = $urandom_range(16, 36);
      end
      PARTIAL_SCALE: begin
        write_reg(REG_FB_WIDTH, fw);
        write_reg(REG_FB_HEIGHT, fh);
        write_reg(REG_SRC_WIDTH, DIM_W'($urandom_range(fw / 3 + 1, (fw > 1) ? fw : 1)));
        write_reg(REG_SRC_HEIGHT, DIM_W'($urandom_range(1, 3)));
      end
      OVERSIZED_SOURCE: begin
        fw = DIM_W'($urandom_range(0, 12));
        fh = DIM_W'($urandom_range(0, 5));
        write_reg(REG_FB_WIDTH, fw);
        write_reg(REG_FB_HEIGHT, fh);
        write_reg(REG_SRC_WIDTH, fw + DIM_W'($urandom_range(1, 6)));
        write_reg(REG_SRC_HEIGHT, fh + DIM_W'($urandom_range(1, 3)));
        write_reg(REG_TEN_BIT_MODE, ten_data(1'($urandom_range(0, 1))));
        npx = $urandom_range(20, 40);
      end
      MID_FRAME_EDIT: begin
        case ($urandom_range(0, 2))
          0: write_reg(REG_FB_WIDTH, DIM_W'($urandom_range(0, 2047)));
          1: begin
            write_reg(REG_SRC_WIDTH, DIM_W'($urandom_range(1, 4)));
            write_reg(REG_SRC_HEIGHT, DIM_W'($urandom_range(1, 3)));
          end
          default: begin
            write_reg(REG_FB_HEIGHT, DIM_W'($urandom_range(0, 2047)));
            write_reg(REG_TEN_BIT_MODE, ten_data(1'($urandom_range(0, 1))));
          end
        endcase
        npx = 20;
      end
      EMPTY_SOURCE: begin
        case ($urandom_range(0, 2))
          0: write_reg(REG_SRC_WIDTH, '0);
          1: write_reg(REG_SRC_HEIGHT, '0);
          default: begin
            write_reg(REG_SRC_WIDTH, '0);
            write_reg(REG_SRC_HEIGHT, '0);
          end
        endcase
        npx = 4;
      end
      default: begin
        write_reg(REG_FB_WIDTH, DIM_W'($urandom_range(0, 2047)));
        write_reg(REG_FB_HEIGHT, DIM_W'($urandom_range(0, 2047)));
        write_reg(REG_SRC_WIDTH, DIM_W'($urandom_range(0, 2047)));
        write_reg(REG_SRC_HEIGHT, DIM_W'($urandom_range(0, 2047)));
        write_reg(REG_TEN_BIT_MODE, ten_data(1'($urandom_range(0, 1))));
      end
    endcase
    cfg.valid <= 1'b0;
    send_random_pixels(npx);
    settle();
  endtask

  initial begin
    rst       <= 1'b1;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data  <= '0;
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset setting at scale three, both packings and color extremes.
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h96, 8'h69, 8'h3c);
    settle();
    write_reg(REG_TEN_BIT_MODE, 11'h001);
    cfg.valid <= 1'b0;
    send_pixel(8'hff, 8'h00, 8'h80);
    send_pixel(8'h00, 8'hff, 8'h7f);
    send_pixel(8'h40, 8'hbf, 8'h01);
    settle();

    // Widest framebuffer, so the pitch rounds up to the full 2048.
    choose_pacing();
    realign();
    write_reg(REG_FB_WIDTH, 11'h7ff);
    write_reg(REG_FB_HEIGHT, 11'h7ff);
    write_reg(REG_SRC_WIDTH, 11'd2);
    write_reg(REG_SRC_HEIGHT, 11'd2);
    write_reg(REG_TEN_BIT_MODE, 11'h7ff);
    cfg.valid <= 1'b0;
    send_random_pixels(5);
    settle();

    // Source larger than the framebuffer: clipped and fully dropped writes.
    choose_pacing();
    realign();
    write_reg(REG_FB_WIDTH, 11'd3);
    write_reg(REG_FB_HEIGHT, 11'd2);
    write_reg(REG_SRC_WIDTH, 11'd4);
    write_reg(REG_SRC_HEIGHT, 11'd3);
    write_reg(REG_TEN_BIT_MODE, 11'h7fe);
    cfg.valid <= 1'b0;
    send_random_pixels(5);
    settle();

    // Empty source: pixels are taken but cause nothing.
    write_reg(REG_SRC_WIDTH, '0);
    cfg.valid <= 1'b0;
    send_random_pixels(2);
    settle();

    useful_pixels = 0;
    while (useful_pixels < RANDOM_PIXELS) run_random_phase();

    $display("Ran %0d register settings: %0d source pixels (%0d into an empty source),",
             settings_run, pixels_seen, ignored_pixels);
    $display("  %0d framebuffer writes compared, %0d mismatches.", writes_seen, fail_count);
    if (fail_count == 0 && writes_pending == 0) begin
      $display("tiled_framebuffer_scaled_blit_tb: PASS");
    end else begin
      $display("tiled_framebuffer_scaled_blit_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tfsb_pkg.sv
rtl/tfsb_pix_if.sv
rtl/tfsb_wr_if.sv
rtl/tfsb_cfg_if.sv
rtl/tfsb_regs.sv
rtl/tfsb_front.sv
rtl/tfsb_queue.sv
rtl/tfsb_back.sv
rtl/tiled_framebuffer_scaled_blit.sv
rtl/tfsb_checker.sv
test/tfsb_write_checker.sv
test/tiled_framebuffer_scaled_blit_tb.sv
